// File: rtl/n_queens_first_solution_macros.svh
// Assertion macros used by the engine RTL. Each expects clk and rst_n in scope.
`ifndef N_QUEENS_FIRST_SOLUTION_MACROS_SVH
`define N_QUEENS_FIRST_SOLUTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NQFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NQFS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nqfs_pkg.sv
`timescale 1ns / 1ps
package nqfs_pkg;

    localparam int MAX_N_DEF = 16;

    localparam int SIZE_W = 5;
    localparam int COL_W  = 4;
    localparam int ROW_W  = 4;

    typedef struct packed {
        logic [COL_W-1:0] column_index;
        logic [ROW_W-1:0] queen_row;
        logic             found;
        logic             last_of_run;
    } result_t;

endpackage

// File: rtl/nqfs_size_if.sv
`timescale 1ns / 1ps
interface nqfs_size_if;
    logic                        valid;
    logic                        ready;
    logic [nqfs_pkg::SIZE_W-1:0] board_size;

    modport source (output valid, output board_size, input ready);
    modport sink   (input valid, input board_size, output ready);
endinterface

// File: rtl/nqfs_result_if.sv
`timescale 1ns / 1ps
interface nqfs_result_if;
    logic                       valid;
    logic                       ready;
    logic [nqfs_pkg::COL_W-1:0] column_index;
    logic [nqfs_pkg::ROW_W-1:0] queen_row;
    logic                       found;
    logic                       last_of_run;

    modport source (output valid, output column_index, output queen_row,
                    output found, output last_of_run, input ready);
    modport sink   (input valid, input column_index, input queen_row,
                    input found, input last_of_run, output ready);
endinterface

// File: rtl/nqfs_stack_ram.sv
`timescale 1ns / 1ps
module nqfs_stack_ram #(
    parameter int DEPTH = nqfs_pkg::MAX_N_DEF,
    parameter int WIDTH = $clog2(nqfs_pkg::MAX_N_DEF)
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nqfs_engine.sv
`timescale 1ns / 1ps
`include "n_queens_first_solution_macros.svh"
module nqfs_engine #(
    parameter int MAX_N = nqfs_pkg::MAX_N_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start_valid,
    output logic                       start_ready,
    input  logic [$clog2(MAX_N+1)-1:0] start_n,
    output logic                       res_valid,
    input  logic                       res_ready,
    output nqfs_pkg::result_t          res
);

    localparam int CW = $clog2(MAX_N + 1);
    localparam int AW = $clog2(MAX_N);
    localparam int DN = 2 * MAX_N - 1;
    localparam int DW = $clog2(DN);

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_SCAN      = 5'b00010,
        S_POP       = 5'b00100,
        S_EMIT_SEND = 5'b01000,
        S_FAIL_SEND = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   row_reg, row_next;
    logic [MAX_N-1:0] row_mask_reg, row_mask_next;
    logic [DN-1:0]   rise_mask_reg, rise_mask_next;
    logic [DN-1:0]   fall_mask_reg, fall_mask_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [AW-1:0]   ram_rdata;

    logic [AW-1:0]   t_row;
    logic [AW-1:0]   t_col;
    logic [DW-1:0]   rise_idx, fall_idx;
    logic            cell_free;
    logic            toggle;
    logic [CW-1:0]   col_inc, col_dec;
    logic            emit_last;

    nqfs_stack_ram #(
        .DEPTH (MAX_N),
        .WIDTH (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (row_reg[AW-1:0]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The cell under test is the scanned row while searching, and the row read back
    // from the stack while backing out of a column.
    assign t_row    = (state_reg == S_POP) ? ram_rdata : row_reg[AW-1:0];
    assign t_col    = col_reg[AW-1:0];
    assign rise_idx = DW'(t_row) + DW'(t_col);
    assign fall_idx = DW'(t_col) + DW'(n_reg) - DW'(1) - DW'(t_row);
    assign cell_free = !row_mask_reg[t_row] && !rise_mask_reg[rise_idx]
                       && !fall_mask_reg[fall_idx];

    assign col_inc   = col_reg + CW'(1);
    assign col_dec   = col_reg - CW'(1);
    assign emit_last = (col_inc == n_reg);

    assign ram_waddr = t_col;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        row_mask_next  = row_mask_reg;
        rise_mask_next = rise_mask_reg;
        fall_mask_next = fall_mask_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = col_reg[AW-1:0];
        toggle         = 1'b0;
        start_ready    = 1'b0;
        res_valid      = 1'b0;
        res            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                start_ready = 1'b1;
                if (start_valid)
                begin
                    n_next         = start_n;
                    col_next       = '0;
                    row_next       = '0;
                    row_mask_next  = '0;
                    rise_mask_next = '0;
                    fall_mask_next = '0;
                    state_next     = (start_n == '0) ? S_FAIL_SEND : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (col_reg == n_reg)
                begin
                    // Board complete: fetch column 0 for the first beat.
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    col_next   = '0;
                    state_next = S_EMIT_SEND;
                end
                else if (row_reg == n_reg)
                begin
                    if (col_reg == '0)
                    begin
                        state_next = S_FAIL_SEND;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = col_dec[AW-1:0];
                        col_next   = col_dec;
                        state_next = S_POP;
                    end
                end
                else if (cell_free)
                begin
                    toggle   = 1'b1;
                    ram_we   = 1'b1;
                    col_next = col_inc;
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + CW'(1);
                end
            end
            S_POP:
            begin
                toggle     = 1'b1;
                row_next   = CW'(ram_rdata) + CW'(1);
                state_next = S_SCAN;
            end
            S_EMIT_SEND:
            begin
                res_valid        = 1'b1;
                res.column_index = nqfs_pkg::COL_W'(col_reg);
                res.queen_row    = nqfs_pkg::ROW_W'(ram_rdata);
                res.found        = 1'b1;
                res.last_of_run  = emit_last;
                if (res_ready)
                begin
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = col_inc[AW-1:0];
                        col_next  = col_inc;
                    end
                end
            end
            S_FAIL_SEND:
            begin
                res_valid       = 1'b1;
                res.last_of_run = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (toggle)
        begin
            row_mask_next[t_row]     = ~row_mask_reg[t_row];
            rise_mask_next[rise_idx] = ~rise_mask_reg[rise_idx];
            fall_mask_next[fall_idx] = ~fall_mask_reg[fall_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_mask_reg  <= '0;
            rise_mask_reg <= '0;
            fall_mask_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_mask_reg  <= row_mask_next;
            rise_mask_reg <= rise_mask_next;
            fall_mask_reg <= fall_mask_next;
        end
    end

    `NQFS_ASSERT_IMP(a_no_rw_same_cycle, ram_we, !ram_re, "stack written and read in one cycle")
    `NQFS_ASSERT_IMP(a_scan_bounds, state_reg == S_SCAN,
        col_reg <= n_reg && row_reg <= n_reg, "search position beyond board")
    `NQFS_ASSERT_IMP(a_full_board, state_reg == S_EMIT_SEND,
        $countones(row_mask_reg) == int'(n_reg), "solution emitted with rows unplaced")
    `NQFS_ASSERT_NXT(a_start_clears, state_reg == S_IDLE && start_valid,
        row_mask_reg == '0 && rise_mask_reg == '0 && col_reg == '0,
        "new search did not start from an empty board")

endmodule

// File: rtl/n_queens_first_solution.sv
`timescale 1ns / 1ps
// Search: a backtracking search over row trials and backtracks, then one beat per column;
// the search grows steeply with the board size.
// Throughput: one board at a time; the next size is taken once the last beat has left
// the engine. Results then pass the output register at one per cycle when not stalled.
// Reset: asynchronous, active low; clears control state and masks, the row stack is not cleared.
module n_queens_first_solution #(
    parameter int MAX_N = nqfs_pkg::MAX_N_DEF
) (
    input logic           clk,
    input logic           rst_n,
    nqfs_size_if.sink     size_ch,
    nqfs_result_if.source result_ch
);

    localparam int CW = $clog2(MAX_N + 1);

    logic              eng_res_valid;
    logic              eng_res_ready;
    nqfs_pkg::result_t eng_res;
    logic [CW-1:0]     n_sat;

    logic              out_valid_reg;
    nqfs_pkg::result_t out_data_reg;

    // Sizes above the supported maximum saturate.
    assign n_sat = (32'(size_ch.board_size) > MAX_N) ? CW'(MAX_N) : CW'(size_ch.board_size);

    nqfs_engine #(
        .MAX_N (MAX_N)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_valid (size_ch.valid),
        .start_ready (size_ch.ready),
        .start_n     (n_sat),
        .res_valid   (eng_res_valid),
        .res_ready   (eng_res_ready),
        .res         (eng_res)
    );

    assign eng_res_ready = !out_valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_res_ready)
        begin
            out_valid_reg <= eng_res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_ready && eng_res_valid)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.column_index = out_data_reg.column_index;
    assign result_ch.queen_row    = out_data_reg.queen_row;
    assign result_ch.found        = out_data_reg.found;
    assign result_ch.last_of_run  = out_data_reg.last_of_run;

endmodule

// File: test/n_queens_first_solution_tb.sv
`timescale 1ns / 1ps
module n_queens_first_solution_tb;

    localparam int BOARD_MAX = nqfs_pkg::MAX_N_DEF;
    localparam int RANDOM_BOARDS = 96;

    logic clk;
    logic rst_n;

    nqfs_size_if   size_ch ();
    nqfs_result_if result_ch ();

    n_queens_first_solution DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_ch   (size_ch.sink),
        .result_ch (result_ch.source)
    );

    nqfs_pkg::result_t pending_placements[$];
    int                error_count;
    int                hold_off_cycles;
    bit                no_idle;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one; none while no_idle is set.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Depth-first search for the first placement, rows tried in ascending order.
    function automatic void solve_board(input logic [nqfs_pkg::SIZE_W-1:0] size);
        int                     n;
        int                     col;
        int                     row;
        int                     placed[BOARD_MAX];
        bit                     done;
        bit                     solved;
        logic [BOARD_MAX-1:0]   rows_used;
        logic [2*BOARD_MAX-2:0] rise_used;
        logic [2*BOARD_MAX-2:0] fall_used;
        nqfs_pkg::result_t      r;
        n = (size > BOARD_MAX) ? BOARD_MAX : int'(size);
        rows_used = '0;
        rise_used = '0;
        fall_used = '0;
        col = 0;
        row = 0;
        done = 1'b0;
        solved = 1'b0;
        while (n > 0 && !done)
        begin
            if (col >= n)
            begin
                solved = 1'b1;
                done = 1'b1;
            end
            else
            begin
                while (row < n && (rows_used[row] || rise_used[row + col]
                                   || fall_used[col + n - 1 - row]))
                    row++;
                if (row < n)
                begin
                    rows_used[row] = 1'b1;
                    rise_used[row + col] = 1'b1;
                    fall_used[col + n - 1 - row] = 1'b1;
                    placed[col] = row;
                    col++;
                    row = 0;
                end
                else if (col == 0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    col--;
                    row = placed[col];
                    rows_used[row] = 1'b0;
                    rise_used[row + col] = 1'b0;
                    fall_used[col + n - 1 - row] = 1'b0;
                    row++;
                end
            end
        end
        if (!solved)
        begin
            r = '0;
            r.last_of_run = 1'b1;
            pending_placements.push_back(r);
        end
        else
        begin
            for (int c = 0; c < n; c++)
            begin
                r.column_index = c[nqfs_pkg::COL_W-1:0];
                r.queen_row = placed[c][nqfs_pkg::ROW_W-1:0];
                r.found = 1'b1;
                r.last_of_run = (c == n - 1);
                pending_placements.push_back(r);
            end
        end
    endfunction

    // valid is only lowered when a gap follows, so it never gets two updates in one step.
    task automatic offer_board(input logic [nqfs_pkg::SIZE_W-1:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            size_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        solve_board(size);
        size_ch.valid <= 1'b1;
        size_ch.board_size <= size;
        @(posedge clk);
        while (!size_ch.ready)
            @(posedge clk);
    endtask

    task automatic test_each_size();
        for (int s = 1; s <= BOARD_MAX; s++)
            offer_board(s[nqfs_pkg::SIZE_W-1:0]);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 10; i++)
            offer_board(nqfs_pkg::SIZE_W'($urandom_range(1, 10)));
        no_idle = 1'b0;
    endtask

    // The receiver stalls for a long stretch while boards keep coming, so the
    // engine backs up and holds off the size channel.
    task automatic test_output_stall();
        hold_off_cycles = 400;
        no_idle = 1'b1;
        for (int i = 0; i < 8; i++)
            offer_board(nqfs_pkg::SIZE_W'($urandom_range(4, 8)));
        no_idle = 1'b0;
    endtask

    // Big boards search for a long time, so only a handful of them.
    task automatic test_random_sizes();
        int big_count;
        big_count = 0;
        for (int i = 0; i < RANDOM_BOARDS; i++)
        begin
            if (i % 20 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (big_count < 4 && $urandom_range(0, 24) == 0)
            begin
                big_count++;
                offer_board(nqfs_pkg::SIZE_W'($urandom_range(14, BOARD_MAX)));
            end
            else
            begin
                offer_board(nqfs_pkg::SIZE_W'($urandom_range(1, 13)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        nqfs_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_placements.size() == 0)
            begin
                $error("unexpected result beat: column %0d row %0d found %0b last %0b",
                       result_ch.column_index, result_ch.queen_row,
                       result_ch.found, result_ch.last_of_run);
                error_count++;
            end
            else
            begin
                want = pending_placements.pop_front();
                if (result_ch.column_index !== want.column_index)
                begin
                    $error("column_index: expected %0d, got %0d",
                           want.column_index, result_ch.column_index);
                    error_count++;
                end
                if (result_ch.queen_row !== want.queen_row)
                begin
                    $error("queen_row: expected %0d, got %0d",
                           want.queen_row, result_ch.queen_row);
                    error_count++;
                end
                if (result_ch.found !== want.found)
                begin
                    $error("found: expected %0b, got %0b", want.found, result_ch.found);
                    error_count++;
                end
                if (result_ch.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, result_ch.last_of_run);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("n_queens_first_solution_tb: FAIL");
        $finish;
    end

    initial
    begin
        error_count = 0;
        hold_off_cycles = 0;
        no_idle = 1'b0;
        rst_n <= 1'b0;
        size_ch.valid <= 1'b0;
        size_ch.board_size <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_size();
        test_back_to_back();
        test_output_stall();
        test_random_sizes();

        size_ch.valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("n_queens_first_solution_tb: PASS");
        else
            $display("n_queens_first_solution_tb: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+rtl
rtl/nqfs_pkg.sv
rtl/nqfs_size_if.sv
rtl/nqfs_result_if.sv
rtl/nqfs_stack_ram.sv
rtl/nqfs_engine.sv
rtl/n_queens_first_solution.sv
test/n_queens_first_solution_tb.sv
